### rtl/nstl_pkg.sv
// Shared types, constants and helper functions for the nearest-site traction lookup.
// No dependencies; the files that use this package refer to it by scoped names.
package nstl_pkg;

   // Table size and fixed-point format.
   localparam int MAX_SITES  = 4096;
   localparam int FRAC_BITS  = 16;
   localparam int IDX_W      = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int CNT_W      = $clog2(MAX_SITES + 1);
   localparam int OUT_IDX_W  = 12;
   localparam int CSR_ADDR_W = 5;
   localparam int POS_W      = 96;
   localparam int DATA_W     = 192;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X  = 3'd0,
      REG_ORIGIN_Y  = 3'd1,
      REG_ORIGIN_Z  = 3'd2,
      REG_VOXEL     = 3'd3,
      REG_TRAC_OFS  = 3'd4,
      REG_TANG_OFS  = 3'd5
   } reg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LD_MUL,
      S_LD_ADD,
      S_LD_WR,
      S_SCAN,
      S_FETCH,
      S_FETCH_WAIT,
      S_F_MUL,
      S_F_RND,
      S_M_MUL,
      S_M_ACC,
      S_ROOT_START,
      S_ROOT_WAIT,
      S_FINISH
   } state_type;

   // Square-root unit handshake.
   typedef struct packed {
      logic busy;
      logic done;
   } root_stat_type;

   // Saturate a 64-bit signed value to 32 bits.
   function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Magnitude of a 32-bit signed value; the most negative value maps to 2^31.
   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

endpackage

### rtl/nstl_channels.sv
// Channel interfaces for request and response words of the lookup block.
// Depends on nstl_pkg for the index width.
interface nstl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [31:0] vec_x;
   logic signed [31:0] vec_y;
   logic signed [31:0] vec_z;
   logic signed [31:0] traction_x;
   logic signed [31:0] traction_y;
   logic signed [31:0] traction_z;
   logic signed [31:0] tangent_x;
   logic signed [31:0] tangent_y;
   logic signed [31:0] tangent_z;
   logic [30:0]        cell_area;

   modport source (output valid, operation, vec_x, vec_y, vec_z, traction_x, traction_y,
                   traction_z, tangent_x, tangent_y, tangent_z, cell_area, input ready);
   modport sink (input valid, operation, vec_x, vec_y, vec_z, traction_x, traction_y,
                 traction_z, tangent_x, tangent_y, tangent_z, cell_area, output ready);
endinterface

interface nstl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic [nstl_pkg::OUT_IDX_W-1:0]  nearest_index;
   logic signed [31:0]              force_x;
   logic signed [31:0]              force_y;
   logic signed [31:0]              force_z;
   logic [30:0]                     force_mag;
   logic signed [31:0]              shear_x;
   logic signed [31:0]              shear_y;
   logic signed [31:0]              shear_z;
   logic [30:0]                     shear_mag;

   modport source (output valid, status, nearest_index, force_x, force_y, force_z, force_mag,
                   shear_x, shear_y, shear_z, shear_mag, input ready);
   modport sink (input valid, status, nearest_index, force_x, force_y, force_z, force_mag,
                 shear_x, shear_y, shear_z, shear_mag, output ready);
endinterface

### rtl/nearest_site_traction_lookup_core.sv
// Top level of the nearest-site traction lookup: CSR port, sequencer and site tables.
// Depends on nstl_pkg, nstl_channels, nstl_ram and nstl_isqrt.
//
//   Channel   Direction  Handshake           Content
//   req       in         valid/ready         operation, position, tractions, area
//   rsp       out        valid/ready         status, index, force, shear, magnitudes
//   csr       in/out     APB psel/penable    six 32-bit configuration registers
//
// One word is processed at a time. Clear, no-op, a dropped load and a query on an
// empty table go straight to the finish state; a load scales each axis, then writes.
// A query reads the position memory once per stored site and drains the scan pipeline,
// then uses the shared multiplier and runs the square-root unit twice.
// Reset is synchronous; the tables need no clearing pass after reset.
// A finished word waits in the output register while the next request is taken.
module nearest_site_traction_lookup_core (
   input  logic                              clock,
   input  logic                              reset,
   nstl_req_if.sink                          req,
   nstl_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nstl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int IW       = nstl_pkg::IDX_W;
   localparam int CW       = nstl_pkg::CNT_W;
   localparam int POS_W_L  = nstl_pkg::POS_W;
   localparam int DATA_W_L = nstl_pkg::DATA_W;

   // Configuration registers.
   logic signed [31:0] origin_ff [3];
   logic [30:0]        voxel_ff;
   logic signed [31:0] trac_ofs_ff;
   logic signed [31:0] tang_ofs_ff;
   nstl_pkg::reg_type  csr_idx;
   logic               csr_wr;

   // Sequencer.
   nstl_pkg::state_type  state_ff, state_in;
   logic                 req_rdy;
   logic                 pos_we;
   logic                 scan_issue;
   logic                 sqrt_start;
   logic                 fin_go;
   logic [CW-1:0]        count_ff;
   logic [1:0]           axis_ff;
   logic                 magsel_ff;

   // Latched request word.
   logic signed [31:0]   vec_ff [3];
   logic signed [31:0]   trac_raw_ff [3];
   logic signed [31:0]   tang_raw_ff [3];
   logic [30:0]          area_ff;

   // Shared multiplier.
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   mul_p;
   logic signed [63:0]   prod_ff;

   // Load datapath.
   logic signed [31:0]   pos_ff [3];
   logic [POS_W_L-1:0]   pos_wdata;
   logic [DATA_W_L-1:0]  data_wdata;

   // Scan pipeline.
   logic [CW-1:0]        rd_idx_ff;
   logic                 p0_vld_ff, p1_vld_ff, p2_vld_ff;
   logic [IW-1:0]        p0_idx_ff, p1_idx_ff, p2_idx_ff;
   logic [63:0]          sq_ff [3];
   logic [65:0]          dist_ff;
   logic                 best_vld_ff;
   logic [65:0]          best_dist_ff;
   logic [IW-1:0]        best_idx_ff;
   logic [POS_W_L-1:0]   pos_rdata;
   logic [DATA_W_L-1:0]  data_rdata;
   logic [31:0]          dabs [3];
   logic signed [32:0]   diff [3];

   // Result datapath.
   logic signed [31:0]   trac_ff [3];
   logic signed [31:0]   tang_ff [3];
   logic signed [31:0]   force_ff [3];
   logic [63:0]          acc_ff;
   logic [30:0]          fmag_ff, smag_ff;
   logic [63:0]          rnd;
   logic signed [31:0]   rnd_res;
   logic signed [31:0]   mag_comp;
   logic [30:0]          root_sat;
   nstl_pkg::status_type res_status_ff;
   logic                 res_query_ff;
   nstl_pkg::root_stat_type root_stat;
   logic [31:0]          root_val;

   // Output register.
   logic                 rsp_vld_ff;
   logic [1:0]           o_status_ff;
   logic [nstl_pkg::OUT_IDX_W-1:0] o_idx_ff;
   logic signed [31:0]   o_force_ff [3];
   logic signed [31:0]   o_shear_ff [3];
   logic [30:0]          o_fmag_ff, o_smag_ff;

   // CSR decode; pready is tied high so a write completes in its access cycle.
   assign csr_pready = 1'b1;
   assign csr_idx    = nstl_pkg::reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_idx)
         nstl_pkg::REG_ORIGIN_X: csr_prdata = origin_ff[0];
         nstl_pkg::REG_ORIGIN_Y: csr_prdata = origin_ff[1];
         nstl_pkg::REG_ORIGIN_Z: csr_prdata = origin_ff[2];
         nstl_pkg::REG_VOXEL:    csr_prdata = {1'b0, voxel_ff};
         nstl_pkg::REG_TRAC_OFS: csr_prdata = trac_ofs_ff;
         nstl_pkg::REG_TANG_OFS: csr_prdata = tang_ofs_ff;
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         voxel_ff     <= 31'd65536;
         trac_ofs_ff  <= '0;
         tang_ofs_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            nstl_pkg::REG_ORIGIN_X: origin_ff[0] <= csr_pwdata;
            nstl_pkg::REG_ORIGIN_Y: origin_ff[1] <= csr_pwdata;
            nstl_pkg::REG_ORIGIN_Z: origin_ff[2] <= csr_pwdata;
            nstl_pkg::REG_VOXEL:    voxel_ff     <= csr_pwdata[30:0];
            nstl_pkg::REG_TRAC_OFS: trac_ofs_ff  <= csr_pwdata;
            nstl_pkg::REG_TANG_OFS: tang_ofs_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Next state and strobes.
   always_comb begin
      state_in   = state_ff;
      req_rdy    = 1'b0;
      pos_we     = 1'b0;
      scan_issue = 1'b0;
      sqrt_start = 1'b0;
      fin_go     = 1'b0;
      unique case (state_ff)
         nstl_pkg::S_IDLE: begin
            req_rdy = 1'b1;
            if (req.valid) begin
               unique case (nstl_pkg::op_type'(req.operation))
                  nstl_pkg::OP_LOAD:
                     state_in = (count_ff == CW'(nstl_pkg::MAX_SITES)) ?
                                nstl_pkg::S_FINISH : nstl_pkg::S_LD_MUL;
                  nstl_pkg::OP_QUERY:
                     state_in = (count_ff == '0) ? nstl_pkg::S_FINISH : nstl_pkg::S_SCAN;
                  nstl_pkg::OP_CLEAR, nstl_pkg::OP_NONE:
                     state_in = nstl_pkg::S_FINISH;
                  default: state_in = nstl_pkg::S_FINISH;
               endcase
            end
         end
         nstl_pkg::S_LD_MUL: state_in = nstl_pkg::S_LD_ADD;
         nstl_pkg::S_LD_ADD:
            state_in = (axis_ff == 2'd2) ? nstl_pkg::S_LD_WR : nstl_pkg::S_LD_MUL;
         nstl_pkg::S_LD_WR: begin
            pos_we   = 1'b1;
            state_in = nstl_pkg::S_FINISH;
         end
         nstl_pkg::S_SCAN: begin
            scan_issue = (rd_idx_ff < count_ff);
            if (!scan_issue && !p0_vld_ff && !p1_vld_ff && !p2_vld_ff) begin
               state_in = nstl_pkg::S_FETCH;
            end
         end
         nstl_pkg::S_FETCH:      state_in = nstl_pkg::S_FETCH_WAIT;
         nstl_pkg::S_FETCH_WAIT: state_in = nstl_pkg::S_F_MUL;
         nstl_pkg::S_F_MUL:      state_in = nstl_pkg::S_F_RND;
         nstl_pkg::S_F_RND:
            state_in = (axis_ff == 2'd2) ? nstl_pkg::S_M_MUL : nstl_pkg::S_F_MUL;
         nstl_pkg::S_M_MUL:      state_in = nstl_pkg::S_M_ACC;
         nstl_pkg::S_M_ACC:
            state_in = (axis_ff == 2'd2) ? nstl_pkg::S_ROOT_START : nstl_pkg::S_M_MUL;
         nstl_pkg::S_ROOT_START: begin
            sqrt_start = 1'b1;
            state_in   = nstl_pkg::S_ROOT_WAIT;
         end
         nstl_pkg::S_ROOT_WAIT: begin
            if (root_stat.done) begin
               state_in = magsel_ff ? nstl_pkg::S_FINISH : nstl_pkg::S_M_MUL;
            end
         end
         nstl_pkg::S_FINISH: begin
            fin_go = !rsp_vld_ff || rsp.ready;
            if (fin_go) begin
               state_in = nstl_pkg::S_IDLE;
            end
         end
         default: state_in = nstl_pkg::S_IDLE;
      endcase
   end

   assign req.ready = req_rdy;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= nstl_pkg::S_IDLE;
         count_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
         p0_vld_ff   <= 1'b0;
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         p0_vld_ff <= scan_issue;
         p1_vld_ff <= p0_vld_ff;
         p2_vld_ff <= p1_vld_ff;
         if (req_rdy && req.valid) begin
            best_vld_ff <= 1'b0;
            if (nstl_pkg::op_type'(req.operation) == nstl_pkg::OP_CLEAR) begin
               count_ff <= '0;
            end
         end else if (p2_vld_ff && (!best_vld_ff || dist_ff < best_dist_ff)) begin
            best_vld_ff <= 1'b1;
         end
         if (pos_we) begin
            count_ff <= count_ff + CW'(1);
         end
         if (fin_go) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      mag_comp = magsel_ff ? tang_ff[axis_ff] : force_ff[axis_ff];
      unique case (state_ff)
         nstl_pkg::S_LD_MUL: begin
            mul_a = $signed({2'b00, voxel_ff});
            mul_b = {vec_ff[axis_ff][31], vec_ff[axis_ff]};
         end
         nstl_pkg::S_F_MUL: begin
            mul_a = $signed({1'b0, nstl_pkg::abs32(trac_ff[axis_ff])});
            mul_b = $signed({2'b00, area_ff});
         end
         default: begin
            mul_a = $signed({1'b0, nstl_pkg::abs32(mag_comp)});
            mul_b = $signed({1'b0, nstl_pkg::abs32(mag_comp)});
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Round half away from zero at the binary point, then saturate with sign.
   always_comb begin
      rnd = 64'(prod_ff) + (64'd1 << (nstl_pkg::FRAC_BITS - 1));
      rnd = rnd >> nstl_pkg::FRAC_BITS;
      if (!trac_ff[axis_ff][31]) begin
         rnd_res = (rnd > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(rnd[31:0]);
      end else begin
         rnd_res = (rnd > 64'h80000000) ? 32'sh80000000 : $signed(-rnd[31:0]);
      end
      root_sat = root_val[31] ? 31'h7FFFFFFF : root_val[30:0];
   end

   // Scan stage one: per-axis distance magnitude.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = {vec_ff[k][31], vec_ff[k]} - {pos_rdata[32*k+31], pos_rdata[32*k +: 32]};
         dabs[k] = diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
      end
   end

   // Memory write words.
   always_comb begin
      pos_wdata  = {pos_ff[2], pos_ff[1], pos_ff[0]};
      for (int k = 0; k < 3; k++) begin
         data_wdata[32*k +: 32] = nstl_pkg::sat_s32(64'(trac_raw_ff[k]) + 64'(trac_ofs_ff));
         data_wdata[96+32*k +: 32] =
            nstl_pkg::sat_s32(64'(tang_raw_ff[k]) + 64'(tang_ofs_ff));
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_rdy && req.valid) begin
         vec_ff[0]      <= req.vec_x;
         vec_ff[1]      <= req.vec_y;
         vec_ff[2]      <= req.vec_z;
         trac_raw_ff[0] <= req.traction_x;
         trac_raw_ff[1] <= req.traction_y;
         trac_raw_ff[2] <= req.traction_z;
         tang_raw_ff[0] <= req.tangent_x;
         tang_raw_ff[1] <= req.tangent_y;
         tang_raw_ff[2] <= req.tangent_z;
         area_ff        <= req.cell_area;
         axis_ff        <= 2'd0;
         magsel_ff      <= 1'b0;
         rd_idx_ff      <= '0;
         res_query_ff   <= 1'b0;
         unique case (nstl_pkg::op_type'(req.operation))
            nstl_pkg::OP_LOAD:
               res_status_ff <= (count_ff == CW'(nstl_pkg::MAX_SITES)) ?
                                nstl_pkg::STAT_FULL : nstl_pkg::STAT_DONE;
            nstl_pkg::OP_QUERY:
               res_status_ff <= (count_ff == '0) ? nstl_pkg::STAT_EMPTY : nstl_pkg::STAT_DONE;
            nstl_pkg::OP_CLEAR, nstl_pkg::OP_NONE:
               res_status_ff <= nstl_pkg::STAT_DONE;
            default: res_status_ff <= nstl_pkg::STAT_DONE;
         endcase
      end

      // Multiplier output register.
      if (state_ff == nstl_pkg::S_LD_MUL || state_ff == nstl_pkg::S_F_MUL ||
          state_ff == nstl_pkg::S_M_MUL) begin
         prod_ff <= mul_p[63:0];
      end

      // Per-axis steps advance the axis and wrap after z.
      if (state_ff == nstl_pkg::S_LD_ADD || state_ff == nstl_pkg::S_F_RND ||
          state_ff == nstl_pkg::S_M_ACC) begin
         axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
      end

      if (state_ff == nstl_pkg::S_LD_ADD) begin
         pos_ff[axis_ff] <= nstl_pkg::sat_s32(64'(origin_ff[axis_ff]) + prod_ff);
      end

      // Scan pipeline payload.
      if (scan_issue) begin
         rd_idx_ff <= rd_idx_ff + CW'(1);
      end
      p0_idx_ff <= rd_idx_ff[IW-1:0];
      p1_idx_ff <= p0_idx_ff;
      p2_idx_ff <= p1_idx_ff;
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= dabs[k] * dabs[k];
      end
      dist_ff <= 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
      if (p2_vld_ff && (!best_vld_ff || dist_ff < best_dist_ff)) begin
         best_dist_ff <= dist_ff;
         best_idx_ff  <= p2_idx_ff;
      end

      if (state_ff == nstl_pkg::S_FETCH_WAIT) begin
         for (int k = 0; k < 3; k++) begin
            trac_ff[k] <= data_rdata[32*k +: 32];
            tang_ff[k] <= data_rdata[96+32*k +: 32];
         end
      end

      if (state_ff == nstl_pkg::S_F_RND) begin
         force_ff[axis_ff] <= rnd_res;
         if (axis_ff == 2'd2) begin
            acc_ff <= '0;
         end
      end

      if (state_ff == nstl_pkg::S_M_ACC) begin
         acc_ff <= acc_ff + prod_ff;
      end

      if (state_ff == nstl_pkg::S_ROOT_WAIT && root_stat.done) begin
         acc_ff <= '0;
         if (magsel_ff) begin
            smag_ff      <= root_sat;
            res_query_ff <= 1'b1;
         end else begin
            fmag_ff   <= root_sat;
            magsel_ff <= 1'b1;
         end
      end

      // Output register load.
      if (fin_go) begin
         o_status_ff <= res_status_ff;
         o_idx_ff    <= res_query_ff ? nstl_pkg::OUT_IDX_W'(best_idx_ff) : '0;
         o_fmag_ff   <= res_query_ff ? fmag_ff : '0;
         o_smag_ff   <= res_query_ff ? smag_ff : '0;
         for (int k = 0; k < 3; k++) begin
            o_force_ff[k] <= res_query_ff ? force_ff[k] : '0;
            o_shear_ff[k] <= res_query_ff ? tang_ff[k] : '0;
         end
      end
   end

   // Site tables: positions, and traction with tangent traction.
   nstl_ram #(.WIDTH(POS_W_L), .DEPTH(nstl_pkg::MAX_SITES)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (count_ff[IW-1:0]),
      .wdata (pos_wdata),
      .raddr (rd_idx_ff[IW-1:0]),
      .rdata (pos_rdata)
   );

   nstl_ram #(.WIDTH(DATA_W_L), .DEPTH(nstl_pkg::MAX_SITES)) u_data_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (count_ff[IW-1:0]),
      .wdata (data_wdata),
      .raddr (best_idx_ff),
      .rdata (data_rdata)
   );

   nstl_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff),
      .stat     (root_stat),
      .root     (root_val)
   );

   // Response word.
   assign rsp.valid         = rsp_vld_ff;
   assign rsp.status        = o_status_ff;
   assign rsp.nearest_index = o_idx_ff;
   assign rsp.force_x       = o_force_ff[0];
   assign rsp.force_y       = o_force_ff[1];
   assign rsp.force_z       = o_force_ff[2];
   assign rsp.force_mag     = o_fmag_ff;
   assign rsp.shear_x       = o_shear_ff[0];
   assign rsp.shear_y       = o_shear_ff[1];
   assign rsp.shear_z       = o_shear_ff[2];
   assign rsp.shear_mag     = o_smag_ff;

   // The fill count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(nstl_pkg::MAX_SITES))
      else $error("site count beyond table size");

   // A table write only happens into a free entry.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      pos_we |-> (count_ff < CW'(nstl_pkg::MAX_SITES)))
      else $error("site write into a full table");

   // The fetched winner is a stored site.
   a_best_stored: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nstl_pkg::S_FETCH) |-> (best_vld_ff && (CW'(best_idx_ff) < count_ff)))
      else $error("nearest site outside the table");

   // The scan pipeline only moves words that were issued.
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      p2_vld_ff |-> $past(p0_vld_ff, 2))
      else $error("scan pipeline valid out of order");

   // The root unit is never restarted while running.
   a_root_idle: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !root_stat.busy)
      else $error("square root restarted while busy");

endmodule

### rtl/nstl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module nstl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/nstl_isqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on nstl_pkg for the status struct.
module nstl_isqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             radicand,
   output nstl_pkg::root_stat_type stat,
   output logic [31:0]             root
);

   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [4:0]  iter_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [35:0] rem_t;
   logic [35:0] trial;
   logic        take;

   // One digit step: bring down two bits and try the next root bit.
   always_comb begin
      rem_t = {rem_ff, rad_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      take  = (rem_t >= trial);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            iter_ff <= iter_ff + 5'd1;
            if (iter_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[61:0], 2'b00};
         rem_ff  <= take ? 34'(rem_t - trial) : rem_t[33:0];
         root_ff <= {root_ff[30:0], take};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule
